// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lpcsyn_pkg.sv
// ---------------------------------------------------------------------------
// LPC synthesis filter package
// Widths, codes and the types shared by the filter top level and its
// excitation generator.
// ---------------------------------------------------------------------------
package lpcsyn_pkg;

	// Default ring and coefficient depth.
	localparam int MAX_ORDER_DEF = 16;

	// Field widths.
	localparam int SAMPLE_W   = 16;
	localparam int MODE_W     = 3;
	localparam int SLOT_W     = 4;
	localparam int ORDER_W    = 5;
	localparam int GAIN_W     = 15;
	localparam int PERIOD_W   = 10;
	localparam int SHIFT_W    = 4;
	localparam int LFSR_W     = 16;
	localparam int EXC_W      = 32;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 15;

	// Q5.27 to Q1.15 conversion shift.
	localparam int FRAC_SHIFT = 12;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RESIDUAL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PULSE    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_NOISE    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ZERO     = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_ORDER  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SHIFT  = 2'd3;

	// Configuration reset values.
	localparam logic [ORDER_W-1:0]  ORDER_RST  = 5'd10;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 15'd3277;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd70;
	localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 4'd0;

	// Noise generator.
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

	// Request from the sequencer to the excitation generator.
	typedef struct packed {
		logic                       fire;
		logic [MODE_W-1:0]          mode;
		logic                       block_start;
		logic signed [SAMPLE_W-1:0] residual;
	} exc_req_t;

	// Excitation settings.
	typedef struct packed {
		logic [GAIN_W-1:0]   gain;
		logic [PERIOD_W-1:0] period;
		logic [SHIFT_W-1:0]  shift;
	} exc_cfg_t;

endpackage

// File: rtl/lpcsyn_excite.sv
// ---------------------------------------------------------------------------
// LPC synthesis excitation generator
// Holds the pulse phase and the noise LFSR, steps them when a synthesis item
// is accepted, and registers the item details and then the excitation.
// ---------------------------------------------------------------------------
module lpcsyn_excite (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  lpcsyn_pkg::exc_req_t                    req,
	input  lpcsyn_pkg::exc_cfg_t                    cfg,
	output logic signed [lpcsyn_pkg::EXC_W-1:0]     exc
);
	import lpcsyn_pkg::*;

	logic [MODE_W-1:0]          mode_q;
	logic signed [SAMPLE_W-1:0] resid_q;
	logic                       pulse_q;
	logic [PERIOD_W-1:0]        phase_q;
	logic [LFSR_W-1:0]          lfsr_q;

	logic [PERIOD_W-1:0]        phase_cur;
	logic [PERIOD_W-1:0]        period_eff;
	logic [PERIOD_W:0]          phase_inc;
	logic [PERIOD_W-1:0]        phase_nxt;
	logic [LFSR_W-1:0]          lfsr_step;
	logic [LFSR_W+GAIN_W-1:0]   noise_prod;
	logic signed [EXC_W-1:0]    exc_d;
	logic signed [EXC_W-1:0]    exc_q;

	// Phase for this item: a block start clears it, a zero period counts as one.
	always_comb begin
		phase_cur  = req.block_start ? '0 : phase_q;
		period_eff = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
		phase_inc  = {1'b0, phase_cur} + (PERIOD_W + 1)'(1);
		phase_nxt  = (phase_inc >= {1'b0, period_eff}) ? '0 : phase_inc[PERIOD_W-1:0];
	end

	// One Galois step, shifting right.
	always_comb begin
		if (lfsr_q[0]) begin
			lfsr_step = {1'b0, lfsr_q[LFSR_W-1:1]} ^ LFSR_MASK;
		end else begin
			lfsr_step = {1'b0, lfsr_q[LFSR_W-1:1]};
		end
	end

	// The phase advances on accepted synthesis items, the LFSR on noise items only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			lfsr_q  <= LFSR_SEED;
		end else if (req.fire) begin
			phase_q <= phase_nxt;
			if (req.mode == MODE_NOISE) begin
				lfsr_q <= lfsr_step;
			end
		end
	end

	// Item details kept for the excitation stage.
	always_ff @(posedge clk) begin
		if (req.fire) begin
			mode_q  <= req.mode;
			resid_q <= req.residual;
			pulse_q <= (phase_cur == '0);
		end
	end

	// Excitation select; the noise product keeps its upper fifteen bits.
	assign noise_prod = lfsr_q * cfg.gain;

	always_comb begin
		case (mode_q)
			MODE_RESIDUAL: exc_d = EXC_W'(resid_q) <<< cfg.shift;
			MODE_PULSE:    exc_d = pulse_q ? EXC_W'(cfg.gain) : '0;
			MODE_NOISE:    exc_d = EXC_W'(noise_prod[LFSR_W+GAIN_W-1:LFSR_W]);
			default:       exc_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		exc_q <= exc_d;
	end

	assign exc = exc_q;

endmodule

// File: rtl/lpc_allpole_synthesis_filter_top.sv
// ---------------------------------------------------------------------------
// LPC all-pole synthesis filter
// Memory-based tap sequencer with one multiply-accumulate per cycle.
// ---------------------------------------------------------------------------
// Usage:
// Configuration is written through cfg_we, cfg_addr and cfg_wdata while the
// block is idle; each write takes effect at the next rising edge.
// Input items arrive on in_valid/in_ready. A load item (mode zero) writes one
// coefficient in its accept cycle and produces nothing, so loads can follow
// one another every cycle.
// A synthesis item walks the taps through the coefficient and history
// memories, one tap per cycle, in state RUN, then waits in DRAIN for the tap
// pipeline to empty and in FIN for the output register; the sample is then on
// out_valid/out_ready, and the next item is taken once the block is idle again.
// The tap loop, bound by the single read port of each memory, sets how long
// an item takes.
// An output register holds a finished sample; if the receiver stalls, the
// next item is still accepted and its computation waits in the final stage
// until the register is free.
// Reset returns the configuration to its defaults, clears the coefficient
// and history stores (through per-entry valid bits), the ring pointer and the
// pulse phase, and reseeds the noise LFSR. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lpc_allpole_synthesis_filter_top #(
	parameter int MAX_ORDER = lpcsyn_pkg::MAX_ORDER_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [lpcsyn_pkg::CFG_ADDR_W-1:0]          cfg_addr,
	input  logic [lpcsyn_pkg::CFG_DATA_W-1:0]          cfg_wdata,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [lpcsyn_pkg::MODE_W-1:0]              mode,
	input  logic [lpcsyn_pkg::SLOT_W-1:0]              coef_index,
	input  logic signed [lpcsyn_pkg::SAMPLE_W-1:0]     coef_value,
	input  logic signed [lpcsyn_pkg::SAMPLE_W-1:0]     residual,
	input  logic                                       block_start,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [lpcsyn_pkg::SAMPLE_W-1:0]     sample
);
	import lpcsyn_pkg::*;

	localparam int AW     = $clog2(MAX_ORDER);
	localparam int CW     = $clog2(MAX_ORDER + 1);
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int ACC_W  = PROD_W + CW;
	localparam int RND_W  = ACC_W - FRAC_SHIFT;
	localparam int TOT_W  = ((RND_W > EXC_W) ? RND_W : EXC_W) + 1;

	localparam logic [AW-1:0]           LAST_IDX = AW'(MAX_ORDER - 1);
	localparam logic signed [TOT_W-1:0] SAT_HI   = TOT_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [TOT_W-1:0] SAT_LO   = ~SAT_HI;
	localparam logic [ACC_W-1:0]        RND_BIAS = ACC_W'(2 ** (FRAC_SHIFT - 1));

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	// Configuration registers.
	logic [ORDER_W-1:0]  order_cfg_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [PERIOD_W-1:0] period_q;
	logic [SHIFT_W-1:0]  shift_q;

	// Sequencer.
	logic [1:0]    state_q;
	logic [CW-1:0] tap_q;
	logic [CW-1:0] order_q;
	logic [CW-1:0] order_sat;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] wp_q;
	logic          in_acc;
	logic          syn_acc;
	logic          load_acc;
	logic          issue;
	logic          fin_fire;

	// Memories and their valid bits.
	logic signed [SAMPLE_W-1:0] coef_mem [MAX_ORDER];
	logic signed [SAMPLE_W-1:0] hist_mem [MAX_ORDER];
	logic [MAX_ORDER-1:0]       coef_vld_q;
	logic [MAX_ORDER-1:0]       hist_vld_q;

	// Tap pipeline.
	logic                       tap_s1;
	logic                       tap_s2;
	logic signed [SAMPLE_W-1:0] coef_rd_s1;
	logic signed [SAMPLE_W-1:0] hist_rd_s1;
	logic                       cv_s1;
	logic                       hv_s1;
	logic signed [PROD_W-1:0]   prod_d;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;

	// Final stage.
	logic [ACC_W-1:0]           acc_sum;
	logic signed [RND_W-1:0]    rnd;
	logic signed [EXC_W-1:0]    exc;
	logic signed [TOT_W-1:0]    total;
	logic signed [SAMPLE_W-1:0] y;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	exc_req_t exc_req;
	exc_cfg_t exc_cfg;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_cfg_q <= ORDER_RST;
			gain_q      <= GAIN_RST;
			period_q    <= PERIOD_RST;
			shift_q     <= SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ORDER:  order_cfg_q <= cfg_wdata[ORDER_W-1:0];
				REG_GAIN:   gain_q      <= cfg_wdata[GAIN_W-1:0];
				REG_PERIOD: period_q    <= cfg_wdata[PERIOD_W-1:0];
				REG_SHIFT:  shift_q     <= cfg_wdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input handshake and item decode.
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign syn_acc  = in_acc && (mode != MODE_LOAD);
	assign load_acc = in_acc && (mode == MODE_LOAD) && (32'(coef_index) < MAX_ORDER);
	assign order_sat = (32'(order_cfg_q) > MAX_ORDER) ? CW'(MAX_ORDER) : CW'(order_cfg_q);
	assign issue    = (state_q == ST_RUN) && (tap_q != order_q);
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Tap sequencer and ring pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
			order_q <= '0;
			rp_q    <= '0;
			wp_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (syn_acc) begin
						state_q <= ST_RUN;
						tap_q   <= '0;
						order_q <= order_sat;
						rp_q    <= (wp_q == '0) ? LAST_IDX : wp_q - AW'(1);
					end
				end
				ST_RUN: begin
					if (issue) begin
						tap_q <= tap_q + CW'(1);
						rp_q  <= (rp_q == '0) ? LAST_IDX : rp_q - AW'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!tap_s1 && !tap_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
						wp_q    <= (wp_q == LAST_IDX) ? '0 : wp_q + AW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Valid bits: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			hist_vld_q <= '0;
		end else begin
			if (load_acc) begin
				coef_vld_q[AW'(coef_index)] <= 1'b1;
			end
			if (fin_fire) begin
				hist_vld_q[wp_q] <= 1'b1;
			end
		end
	end

	// Coefficient memory: written by load items, read one tap per cycle.
	always_ff @(posedge clk) begin
		if (load_acc) begin
			coef_mem[AW'(coef_index)] <= coef_value;
		end
		coef_rd_s1 <= coef_mem[tap_q[AW-1:0]];
		cv_s1      <= coef_vld_q[tap_q[AW-1:0]];
	end

	// History ring: the newest sample is written as the item completes.
	always_ff @(posedge clk) begin
		if (fin_fire) begin
			hist_mem[wp_q] <= y;
		end
		hist_rd_s1 <= hist_mem[rp_q];
		hv_s1      <= hist_vld_q[rp_q];
	end

	// Tap pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			tap_s1 <= issue;
			tap_s2 <= tap_s1;
		end
	end

	// Multiply, then accumulate in full precision.
	assign prod_d = coef_rd_s1 * hist_rd_s1;

	always_ff @(posedge clk) begin
		prod_s2 <= (cv_s1 && hv_s1) ? prod_d : '0;
		if (syn_acc) begin
			acc_q <= '0;
		end else if (tap_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Excitation generator.
	always_comb begin
		exc_req.fire        = syn_acc;
		exc_req.mode        = mode;
		exc_req.block_start = block_start;
		exc_req.residual    = residual;
		exc_cfg.gain        = gain_q;
		exc_cfg.period      = period_q;
		exc_cfg.shift       = shift_q;
	end

	lpcsyn_excite u_excite (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (exc_req),
		.cfg    (exc_cfg),
		.exc    (exc)
	);

	// Round half up to Q1.15, add the excitation and saturate.
	always_comb begin
		acc_sum = acc_q + RND_BIAS;
		rnd     = acc_sum[ACC_W-1:FRAC_SHIFT];
		total   = TOT_W'(rnd) + TOT_W'(exc);
		if (total > SAT_HI) begin
			y = SAMPLE_W'(SAT_HI);
		end else if (total < SAT_LO) begin
			y = SAMPLE_W'(SAT_LO);
		end else begin
			y = total[SAMPLE_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			sample_q <= y;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	// Checks on the sequencer.
	`ASSERT_NEXT(a_syn_start, clk, arst_n, syn_acc, (state_q == ST_RUN) && (tap_q == '0), "no walk")
	`ASSERT_AT(a_tap_bound, clk, arst_n, (state_q == ST_RUN) |-> (tap_q <= order_q), "tap overrun")
	`ASSERT_AT(a_fin_drained, clk, arst_n, (state_q == ST_FIN) |-> (!tap_s1 && !tap_s2), "taps busy")
	`ASSERT_NEXT(a_fin_result, clk, arst_n, fin_fire, out_valid && (wp_q != $past(wp_q)), "no result")

endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// LPC all-pole synthesis filter testbench
// Drives coefficient loads and synthesis items through the valid/ready
// input, rewrites the four settings between phases while the filter is idle,
// and compares every output sample with a bit-exact software copy of the
// filter held in a small scoreboard class. Both sides idle at random.
// ---------------------------------------------------------------------------
module testbench;
	import lpcsyn_pkg::*;

	// Software copy of the filter and the queue of samples it has predicted.
	class synth_scoreboard;
		localparam int DEPTH = MAX_ORDER_DEF;

		logic [ORDER_W-1:0]         order;
		logic [GAIN_W-1:0]          gain;
		logic [PERIOD_W-1:0]        period;
		logic [SHIFT_W-1:0]         shift;
		logic signed [SAMPLE_W-1:0] coef [DEPTH];
		logic signed [SAMPLE_W-1:0] ring [DEPTH];
		int                         wr_ptr;
		int                         phase;
		logic [LFSR_W-1:0]          lfsr;
		logic signed [SAMPLE_W-1:0] expected_samples [$];
		int                         errors;

		function new();
			order  = ORDER_RST;
			gain   = GAIN_RST;
			period = PERIOD_RST;
			shift  = SHIFT_RST;
			for (int i = 0; i < DEPTH; i++) begin
				coef[i] = '0;
				ring[i] = '0;
			end
			wr_ptr = 0;
			phase  = 0;
			lfsr   = LFSR_SEED;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_ORDER:  order  = val[ORDER_W-1:0];
				REG_GAIN:   gain   = val[GAIN_W-1:0];
				REG_PERIOD: period = val[PERIOD_W-1:0];
				REG_SHIFT:  shift  = val[SHIFT_W-1:0];
				default: ;
			endcase
		endfunction

		// Work out the effect of one accepted item and queue its sample, if any.
		function void note_item(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] slot,
				logic signed [SAMPLE_W-1:0] cval, logic signed [SAMPLE_W-1:0] resid,
				logic start);
			longint acc;
			longint exc;
			longint total;
			int taps;
			int eff_period;
			int k;
			logic lsb;
			logic signed [SAMPLE_W-1:0] y;

			if (m == MODE_LOAD) begin
				if (int'(slot) < DEPTH)
					coef[slot] = cval;
				return;
			end

			if (start)
				phase = 0;
			eff_period = (period == 0) ? 1 : int'(period);
			taps = (int'(order) > DEPTH) ? DEPTH : int'(order);

			// Prediction over the most recent outputs, newest first.
			acc = 0;
			for (int j = 0; j < taps; j++) begin
				k = (wr_ptr + 2 * DEPTH - 1 - j) % DEPTH;
				acc += longint'(coef[j]) * longint'(ring[k]);
			end

			case (m)
				MODE_RESIDUAL: exc = longint'(resid) <<< shift;
				MODE_PULSE:    exc = (phase == 0) ? longint'(gain) : 0;
				MODE_NOISE: begin
					lsb  = lfsr[0];
					lfsr = lfsr >> 1;
					if (lsb)
						lfsr = lfsr ^ LFSR_MASK;
					exc = (longint'(lfsr) * longint'(gain)) >>> 16;
				end
				default: exc = 0;
			endcase

			// Round half up to Q1.15, add the excitation and saturate.
			total = ((acc + 2048) >>> FRAC_SHIFT) + exc;
			if (total > 32767)
				y = 16'sh7FFF;
			else if (total < -32768)
				y = 16'sh8000;
			else
				y = SAMPLE_W'(total);

			ring[wr_ptr] = y;
			wr_ptr = (wr_ptr + 1) % DEPTH;
			phase = phase + 1;
			if (phase >= eff_period)
				phase = 0;
			expected_samples.push_back(y);
		endfunction

		task report(string what);
			errors++;
			$display("MISMATCH: %s", what);
		endtask

		task check_sample(logic signed [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;
			if (expected_samples.size() == 0) begin
				report($sformatf("sample %0d arrived with none expected", got));
				return;
			end
			want = expected_samples.pop_front();
			if (got !== want)
				report($sformatf("sample %0d, expected %0d", got, want));
		endtask

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEM_TARGET    = 1550;
	localparam int SETTLE_CYCLES  = 30;

	typedef struct {
		logic [MODE_W-1:0]          mode;
		logic [SLOT_W-1:0]          slot;
		logic signed [SAMPLE_W-1:0] cval;
		logic signed [SAMPLE_W-1:0] resid;
		logic                       start;
	} synth_item_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [CFG_ADDR_W-1:0]        cfg_addr;
	logic [CFG_DATA_W-1:0]        cfg_wdata;
	logic                         in_valid;
	logic                         in_ready;
	logic [MODE_W-1:0]            mode;
	logic [SLOT_W-1:0]            coef_index;
	logic signed [SAMPLE_W-1:0]   coef_value;
	logic signed [SAMPLE_W-1:0]   residual;
	logic                         block_start;
	logic                         out_valid;
	logic                         out_ready;
	logic signed [SAMPLE_W-1:0]   sample;

	synth_scoreboard sb;
	logic            calm;
	int              items_sent;
	int              quiet_cycles = 0;
	int              stall_left;

	lpc_allpole_synthesis_filter_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.coef_index  (coef_index),
		.coef_value  (coef_value),
		.residual    (residual),
		.block_start (block_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample      (sample)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// Present one item at a falling edge and hold it until it is accepted.
	task automatic send_item(synth_item_t it);
		in_valid    <= 1'b1;
		mode        <= it.mode;
		coef_index  <= it.slot;
		coef_value  <= it.cval;
		residual    <= it.resid;
		block_start <= it.start;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic pause_input(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_and_pause(synth_item_t it);
		send_item(it);
		pause_input(gap_len());
	endtask

	// Let every expected sample come out, then give the pipeline time to empty.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all four settings on consecutive cycles.
	task automatic write_settings(int ord, int gn, int per, int sh);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_ORDER;
		cfg_wdata <= CFG_DATA_W'(ord);
		@(negedge clk);
		cfg_addr  <= REG_GAIN;
		cfg_wdata <= CFG_DATA_W'(gn);
		@(negedge clk);
		cfg_addr  <= REG_PERIOD;
		cfg_wdata <= CFG_DATA_W'(per);
		@(negedge clk);
		cfg_addr  <= REG_SHIFT;
		cfg_wdata <= CFG_DATA_W'(sh);
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// An item with every field random, then the caller sets what matters.
	function automatic synth_item_t random_item();
		synth_item_t it;
		it.mode  = MODE_W'($urandom);
		it.slot  = SLOT_W'($urandom);
		it.cval  = SAMPLE_W'($urandom);
		it.resid = SAMPLE_W'($urandom);
		it.start = 1'($urandom);
		return it;
	endfunction

	function automatic synth_item_t make_item(logic [MODE_W-1:0] m, int slot, int cval,
			int resid, logic start);
		synth_item_t it;
		it = random_item();
		it.mode  = m;
		it.slot  = SLOT_W'(slot);
		it.cval  = SAMPLE_W'(cval);
		it.resid = SAMPLE_W'(resid);
		it.start = start;
		return it;
	endfunction

	function automatic int pick_residual();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom_range(0, 400) - 200;
		if (r < 80)
			return int'($urandom_range(0, 65535)) - 32768;
		case ($urandom_range(0, 2))
			0: return 32767;
			1: return -32768;
			default: return 0;
		endcase
	endfunction

	// Coefficient for one slot: stable small sets, full-scale noise or extremes.
	function automatic int pick_coef(int style, int taps, int j);
		int lim;
		lim = 3000 / ((taps == 0) ? 1 : taps);
		if (j >= taps || style == 1)
			return int'($urandom_range(0, 65535)) - 32768;
		if (style == 2)
			return $urandom_range(0, 1) ? 32767 : -32768;
		return $urandom_range(0, 2 * lim) - lim;
	endfunction

	// Receiver: ready with random stalls, held high in calm phases.
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm || stall_left == 0) begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < 20)
					stall_left = gap_len();
			end else begin
				out_ready <= 1'b0;
				stall_left--;
			end
		end
	end

	// Monitor and watchdog, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_sample(sample);
			if (in_valid && in_ready)
				sb.note_item(mode, coef_index, coef_value, residual, block_start);
			if (cfg_we)
				sb.write_reg(cfg_addr, cfg_wdata);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		int taps;
		int style;
		int nsyn;
		int blen;
		int r;
		int p;
		int ord;
		int gn;
		int per;
		int sh;
		logic [MODE_W-1:0] bmode;
		synth_item_t it;

		sb           = new();
		calm         = 1'b0;
		items_sent   = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = '0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		mode         = '0;
		coef_index   = '0;
		coef_value   = '0;
		residual     = '0;
		block_start  = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with the reset settings: extremes, every mode and
		// loads that must leave the ring, phase and noise state alone.
		send_and_pause(make_item(MODE_RESIDUAL, 0, 0, 32767, 1'b1));
		send_and_pause(make_item(MODE_RESIDUAL, 0, 0, -32768, 1'b0));
		send_and_pause(make_item(MODE_RESIDUAL, 0, 0, 0, 1'b0));
		send_and_pause(make_item(MODE_PULSE, 0, 0, 0, 1'b1));
		send_and_pause(make_item(MODE_PULSE, 0, 0, 0, 1'b0));
		send_and_pause(make_item(MODE_NOISE, 0, 0, 0, 1'b0));
		send_and_pause(make_item(MODE_NOISE, 0, 0, 0, 1'b1));
		send_and_pause(make_item(MODE_ZERO, 0, 0, 0, 1'b0));
		send_and_pause(make_item(3'd5, 0, 0, 1000, 1'b0));
		send_and_pause(make_item(3'd6, 0, 0, 1000, 1'b0));
		send_and_pause(make_item(3'd7, 0, 0, 1000, 1'b1));
		send_and_pause(make_item(MODE_LOAD, 0, 32767, 0, 1'b1));
		send_and_pause(make_item(MODE_LOAD, 15, -32768, 0, 1'b0));
		send_and_pause(make_item(MODE_LOAD, 9, 4096, 0, 1'b1));
		send_and_pause(make_item(MODE_LOAD, 0, -32768, 0, 1'b0));
		send_and_pause(make_item(MODE_RESIDUAL, 0, 0, 32767, 1'b0));
		send_and_pause(make_item(MODE_ZERO, 0, 0, 0, 1'b0));
		send_and_pause(make_item(MODE_ZERO, 0, 0, 0, 1'b0));
		send_and_pause(make_item(MODE_NOISE, 0, 0, 0, 1'b0));
		send_and_pause(make_item(MODE_PULSE, 0, 0, 0, 1'b1));
		send_and_pause(make_item(MODE_LOAD, 0, 0, 0, 1'b0));
		send_and_pause(make_item(MODE_LOAD, 15, 0, 0, 1'b0));
		send_and_pause(make_item(MODE_LOAD, 9, 0, 0, 1'b0));

		// Phases: new settings (corner values first, then random), a fresh
		// coefficient set, then blocks of synthesis items with the odd stray item mixed in.
		p = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			case (p)
				0: begin ord = 0;  gn = 0;     per = 0;    sh = 0;  end
				1: begin ord = 31; gn = 32767; per = 1023; sh = 15; end
				2: begin ord = 16; gn = 32767; per = 1;    sh = 0;  end
				3: begin ord = 1;  gn = 1;     per = 0;    sh = 15; end
				4: begin ord = 17; gn = 16384; per = 2;    sh = 1;  end
				default: begin
					r   = $urandom_range(0, 9);
					ord = (r == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
					gn  = $urandom_range(0, 32767);
					per = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
						: $urandom_range(1, 24);
					sh  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
						: $urandom_range(0, 4);
				end
			endcase
			write_settings(ord, gn, per, sh);
			calm = (p % 5 == 3);
			taps = (ord > MAX_ORDER_DEF) ? MAX_ORDER_DEF : ord;

			r = $urandom_range(0, 9);
			style = (r < 7) ? 0 : (r < 9) ? 1 : 2;
			for (int j = 0; j < MAX_ORDER_DEF; j++)
				send_and_pause(make_item(MODE_LOAD, j, pick_coef(style, taps, j), 0,
					1'($urandom)));

			nsyn  = $urandom_range(25, 45);
			blen  = $urandom_range(4, 80);
			bmode = MODE_W'($urandom_range(1, 4));
			for (int i = 0; i < nsyn; i++) begin
				it = random_item();
				r  = $urandom_range(0, 99);
				if (r < 85)
					it.mode = bmode;
				else if (r < 94)
					it.mode = MODE_W'($urandom_range(1, 7));
				else begin
					it.mode = MODE_LOAD;
					it.cval = SAMPLE_W'(pick_coef(0, taps, 0));
				end
				it.resid = SAMPLE_W'(pick_residual());
				it.start = (i % blen == 0) || ($urandom_range(0, 49) == 0);
				send_and_pause(it);
			end
			p++;
		end

		// Drain and let the pipeline settle before the verdict.
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d samples never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/lpcsyn_pkg.sv
rtl/lpcsyn_excite.sv
rtl/lpc_allpole_synthesis_filter_top.sv
tb/testbench.sv
